// File: src/lapf_pkg.sv
package lapf_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int COL_SUM_W = PIX_W + 2;   // three pixels
  localparam int SUM_W     = PIX_W + 4;   // nine pixels

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(512);

  localparam int CENTRE_WEIGHT = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);

  typedef logic [PIX_W-1:0] pix_t;

  // one window column, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

endpackage

// File: src/lapf_cell.sv
module lapf_cell (
  input  logic                                clk,
  input  logic                                shift,
  input  lapf_pkg::col_t                      col_in,
  output lapf_pkg::col_t                      col_q,
  output logic [lapf_pkg::COL_SUM_W-1:0]      col_sum
);

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_sum = lapf_pkg::COL_SUM_W'(col_q.top) + lapf_pkg::COL_SUM_W'(col_q.mid)
                 + lapf_pkg::COL_SUM_W'(col_q.bot);

endmodule

// File: src/lapf_linebuf.sv
module lapf_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lapf_pkg::pix_t       wr_pix,
  output lapf_pkg::pix_t       upper_rd,
  output lapf_pkg::pix_t       middle_rd
);

  lapf_pkg::pix_t upper_mem  [DEPTH];
  lapf_pkg::pix_t middle_mem [DEPTH];

  lapf_pkg::pix_t upper_q;
  lapf_pkg::pix_t middle_q;
  logic           fwd;
  lapf_pkg::pix_t fwd_upper;
  lapf_pkg::pix_t fwd_middle;

  // the middle row moves up as the new pixel takes its place
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= middle_rd;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      upper_q  <= upper_mem[rd_addr];
      middle_q <= middle_mem[rd_addr];
    end
  end

  // same-address read and write in one cycle (one-pixel rows): bypass
  always_ff @(posedge clk) begin
    if (en) begin
      fwd        <= wr_en && (wr_addr == rd_addr);
      fwd_upper  <= middle_rd;
      fwd_middle <= wr_pix;
    end
  end

  assign upper_rd  = fwd ? fwd_upper  : upper_q;
  assign middle_rd = fwd ? fwd_middle : middle_q;

endmodule

// File: src/laplacian_3x3_edge_filter.sv
// channel  | direction | signals                              | word
// ---------+-----------+--------------------------------------+--------------------------
// in       | input     | in_valid, in_ready, pixel_in, drain  | one pixel or drain filler
// out      | output    | out_valid, out_ready, pixel_out,     | one filtered pixel
//          |           | frame_last                           |
// cfg      | input     | cfg_we, cfg_index, cfg_data          | frame_width, frame_height
//
// One word per cycle while out_ready holds; an accepted word goes through the line store
// read at the accepting edge, window shift, kernel sum and clamp into the output register.
// Results lag the input stream by frame_width+1 words within a frame.
// Synchronous reset clears the pipeline and position counters; line stores are not cleared.
// The whole pipeline stalls together while the output register is full and not taken.
module laplacian_3x3_edge_filter #(
  parameter int MAX_ROW_PIXELS = 1024,
  parameter int MAX_ROWS       = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lapf_pkg::PIX_W-1:0]        pixel_in,
  input  logic                              drain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lapf_pkg::PIX_W-1:0]        pixel_out,
  output logic                              frame_last,
  input  logic                              cfg_we,
  input  logic [lapf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lapf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_ROW_PIXELS);
  localparam int WW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int SW = lapf_pkg::SUM_W;

  typedef struct packed {
    logic emit;
    logic last;
    logic interior;
    logic col0;
    logic tail_upd;
  } flags_t;

  logic [lapf_pkg::CFG_W-1:0] frame_width;
  logic [lapf_pkg::CFG_W-1:0] frame_height;
  logic [WW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;
  logic                       cfg_hit;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  logic           en;
  logic           take;
  logic           in_frame;
  flags_t         a_flags;
  lapf_pkg::pix_t a_pix;
  logic           col_at_end;

  logic           b_valid;
  lapf_pkg::pix_t b_pix;
  logic [CW-1:0]  b_col;
  flags_t         b_flags;

  lapf_pkg::pix_t up_rd;
  lapf_pkg::pix_t mid_rd;
  lapf_pkg::pix_t tail;

  logic           c_valid;
  flags_t         c_flags;
  lapf_pkg::pix_t c_tail;

  lapf_pkg::col_t                     win_in  [3];
  lapf_pkg::col_t                     win     [3];
  logic [lapf_pkg::COL_SUM_W-1:0]     win_sum [3];
  logic [SW-1:0]                      sum9;
  logic [SW-1:0]                      centre9;
  logic [SW-1:0]                      diff;
  lapf_pkg::pix_t                     lap_pix;
  lapf_pkg::pix_t                     out_pix;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lapf_pkg::CFG_SIZE_RESET;
      frame_height <= lapf_pkg::CFG_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lapf_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        lapf_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (frame_width > MAX_ROW_PIXELS) begin
      w_eff = WW'(MAX_ROW_PIXELS);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HW'(1);
    end else if (frame_height > MAX_ROWS) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  // only a write to a listed register restarts the frame
  assign cfg_hit = cfg_we && ((cfg_index == lapf_pkg::CFG_FRAME_WIDTH)
                           || (cfg_index == lapf_pkg::CFG_FRAME_HEIGHT));

  // position of the incoming word and its decode
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign in_frame = row < RW'(h_eff);
  // a drain word while the frame is still arriving is dropped outright
  assign take     = in_valid && en && !(in_frame && drain);
  assign a_pix    = in_frame ? pixel_in : '0;

  assign col_at_end       = (WW'(col) == (w_eff - WW'(1)));
  assign a_flags.emit     = (row >= RW'(2)) || ((row == RW'(1)) && (col != '0));
  assign a_flags.last     = (col == '0) && (row == (RW'(h_eff) + RW'(1)));
  assign a_flags.interior = (col >= CW'(2)) && (row >= RW'(2)) && (row < RW'(h_eff));
  assign a_flags.col0     = (col == '0);
  assign a_flags.tail_upd = col_at_end;

  always_comb begin
    col_next = col;
    row_next = row;
    if (a_flags.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_at_end) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line store read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pix   <= a_pix;
      b_col   <= col;
      b_flags <= a_flags;
    end
  end

  lapf_linebuf #(
    .DEPTH (MAX_ROW_PIXELS),
    .AW    (CW)
  ) u_linebuf (
    .clk       (clk),
    .en        (en),
    .rd_addr   (col),
    .wr_en     (en && b_valid),
    .wr_addr   (b_col),
    .wr_pix    (b_pix),
    .upper_rd  (up_rd),
    .middle_rd (mid_rd)
  );

  // window: three column cells, new column enters on the right
  assign win_in[2] = '{top: up_rd, mid: mid_rd, bot: b_pix};
  assign win_in[1] = win[2];
  assign win_in[0] = win[1];

  for (genvar i = 0; i < 3; i++) begin : g_cell
    lapf_cell u_cell (
      .clk     (clk),
      .shift   (en && b_valid),
      .col_in  (win_in[i]),
      .col_q   (win[i]),
      .col_sum (win_sum[i])
    );
  end

  // pixel at the end of the row two lines up, output on column 0
  always_ff @(posedge clk) begin
    if (en && b_valid && b_flags.tail_upd) begin
      tail <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid && b_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_flags <= b_flags;
      c_tail  <= tail;
    end
  end

  // kernel: neighbours - 8*centre = all nine - 9*centre
  assign sum9    = SW'(win_sum[0]) + SW'(win_sum[1]) + SW'(win_sum[2]);
  assign centre9 = (SW'(win[1].mid) << $clog2(lapf_pkg::CENTRE_WEIGHT)) + SW'(win[1].mid);
  assign diff    = sum9 - centre9;

  always_comb begin
    if (sum9 <= centre9) begin
      lap_pix = '0;
    end else if (diff > SW'(lapf_pkg::PIX_MAX)) begin
      lap_pix = lapf_pkg::PIX_MAX;
    end else begin
      lap_pix = diff[lapf_pkg::PIX_W-1:0];
    end
    if (c_flags.col0) begin
      out_pix = c_tail;
    end else if (c_flags.interior) begin
      out_pix = lap_pix;
    end else begin
      out_pix = win[1].mid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_out  <= out_pix;
      frame_last <= c_flags.last;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    WW'(col) < w_eff)
    else $error("column counter beyond row width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= RW'(h_eff) + RW'(1))
    else $error("row counter beyond frame tail");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && a_flags.last |=> (col == '0) && (row == '0))
    else $error("frame did not restart after last word");

  a_col0_border: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> !(c_flags.col0 && c_flags.interior))
    else $error("column 0 word flagged as interior");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !en |=> b_valid && $stable(b_col))
    else $error("read stage moved during stall");

endmodule

// File: sim/laplacian_3x3_edge_filter_tb.sv
module laplacian_3x3_edge_filter_tb;

  localparam int LINE_MAX      = 1024;
  localparam int ROW_MAX       = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 850;
  localparam int REPORT_LIMIT  = 10;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // indexes past the register list, writes there must do nothing
  localparam logic [lapf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = lapf_pkg::CFG_IDX_W'(2);
  localparam logic [lapf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = lapf_pkg::CFG_IDX_W'(3);

  typedef struct packed {
    lapf_pkg::pix_t pixel;
    logic last;
  } filtered_t;

  class laplace_board;
    lapf_pkg::pix_t upper_line[LINE_MAX];
    lapf_pkg::pix_t middle_line[LINE_MAX];
    lapf_pkg::pix_t win[3][3];
    int unsigned col, row, out_count;
    logic [lapf_pkg::CFG_W-1:0] width_reg, height_reg;
    filtered_t due_pixels[$];
    int unsigned faults, results_seen, words_in, frames_done;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      width_reg = lapf_pkg::CFG_SIZE_RESET;
      height_reg = lapf_pkg::CFG_SIZE_RESET;
      faults = 0;
      results_seen = 0;
      words_in = 0;
      frames_done = 0;
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      out_count = 0;
      foreach (win[r, k]) win[r][k] = '0;
    endfunction

    function int unsigned clamp_size(logic [lapf_pkg::CFG_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned cur_width();
      return clamp_size(width_reg, LINE_MAX);
    endfunction

    function int unsigned cur_height();
      return clamp_size(height_reg, ROW_MAX);
    endfunction

    function void write_reg(logic [lapf_pkg::CFG_IDX_W-1:0] idx,
                            logic [lapf_pkg::CFG_W-1:0] val);
      case (idx)
        lapf_pkg::CFG_FRAME_WIDTH: begin
          width_reg = val;
          restart();
        end
        lapf_pkg::CFG_FRAME_HEIGHT: begin
          height_reg = val;
          restart();
        end
        default: ;
      endcase
    endfunction

    function void note_word(lapf_pkg::pix_t p, logic d);
      int unsigned w, h, total, t, c;
      lapf_pkg::pix_t tail, up, mid, v;
      int s;
      bit closing;
      w = cur_width();
      h = cur_height();
      total = w * h;
      t = row * w + col;
      words_in++;
      if (t < total) begin
        if (d) return;   // drain word inside the frame is dropped
      end else begin
        p = '0;          // past the frame every word is filler
      end
      c = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
      tail = upper_line[w-1];
      up = upper_line[c];
      mid = middle_line[c];
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = p;
      upper_line[c] = mid;
      middle_line[c] = p;
      if (t >= w + 1) begin
        if (col == 0) begin
          // last column of the row before wraps out of the upper store
          v = tail;
        end else begin
          v = win[1][1];
          if (row >= 2 && row + 1 <= h && col >= 2 && col + 1 <= w) begin
            s = -lapf_pkg::CENTRE_WEIGHT * int'(win[1][1]);
            for (int r = 0; r < 3; r++)
              for (int k = 0; k < 3; k++)
                if (r != 1 || k != 1) s += int'(win[r][k]);
            if (s > int'(lapf_pkg::PIX_MAX)) s = lapf_pkg::PIX_MAX;
            else if (s < 0) s = 0;
            v = lapf_pkg::pix_t'(s);
          end
        end
        out_count++;
        closing = out_count >= total;
        due_pixels.push_back('{pixel: v, last: closing});
        if (closing) begin
          frames_done++;
          restart();
          return;
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
    endfunction

    function void check_word(lapf_pkg::pix_t p, logic l);
      filtered_t exp_px;
      if (due_pixels.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("tb: result with none due: pixel %0d last %0b", p, l);
        return;
      end
      exp_px = due_pixels.pop_front();
      if (exp_px.pixel !== p || exp_px.last !== l) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("tb: result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                   results_seen, exp_px.pixel, exp_px.last, p, l);
      end
      results_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic drain = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic calm = 1'b0;
  lapf_pkg::pix_t pixel_in = '0;
  logic [lapf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lapf_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_ready, out_valid, frame_last;
  lapf_pkg::pix_t pixel_out;

  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned in_stalls = 0;
  int unsigned stream_words = 0;

  laplace_board sb = new();

  laplacian_3x3_edge_filter #(
    .MAX_ROW_PIXELS(LINE_MAX),
    .MAX_ROWS(ROW_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .drain(drain),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .frame_last(frame_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(pixel_in, drain);
      if (out_valid && out_ready) sb.check_word(pixel_out, frame_last);
    end
  end

  // output side: random back-pressure, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && !in_ready) in_stalls <= in_stalls + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: timed out after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic lapf_pkg::pix_t pick_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return lapf_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 15) return $urandom_range(13, 40);
    return $urandom_range(1, 12);
  endfunction

  function automatic int pick_height();
    if ($urandom_range(99) < 5) return 0;
    return $urandom_range(1, 10);
  endfunction

  task automatic send_word(input lapf_pkg::pix_t p, input logic d);
    int gap;
    in_valid <= 1'b1;
    pixel_in <= p;
    drain <= d;
    do @(posedge clk); while (!in_ready);
    gap = (!calm && $urandom_range(99) < 28) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, let every due result out, then allow the pipe to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [lapf_pkg::CFG_IDX_W-1:0] idx,
                         input logic [lapf_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // one frame of random pixels and its tail; broken_at > 0 cuts it short
  task automatic run_frame(input int broken_at, input int hold_at, input bit noisy);
    int unsigned w, total;
    w = sb.cur_width();
    total = w * sb.cur_height();
    for (int i = 0; i < total; i++) begin
      if (broken_at > 0 && i == broken_at) return;
      if (noisy && $urandom_range(99) < 6) send_word(pick_pixel(), 1'b1);
      if (i == hold_at) hold_requests <= hold_requests + 1;
      send_word(pick_pixel(), 1'b0);
      stream_words++;
    end
    // tail: mostly drain words, some plain pixels which count as filler
    for (int i = 0; i <= w; i++) begin
      send_word(pick_pixel(), $urandom_range(99) >= 25);
      stream_words++;
    end
  endtask

  initial begin : stimulus
    lapf_pkg::pix_t grid[12];
    int frame_no, fw, fh, broken_at, hold_at;
    int unsigned base, total;
    bit must_write;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset size, part of a frame, output held off, then restart by a write
    for (int i = 0; i < 540; i++) begin
      if (i == 500) hold_requests <= hold_requests + 1;
      send_word(pick_pixel(), 1'b0);
      stream_words++;
    end
    set_reg(lapf_pkg::CFG_FRAME_WIDTH, lapf_pkg::CFG_W'(4));
    set_reg(lapf_pkg::CFG_FRAME_HEIGHT, lapf_pkg::CFG_W'(3));

    // both clamp limits on the two interior pixels
    grid = '{8'hFF, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'h00, 8'hFF, 8'hFF,
             8'hFF, 8'hFF, 8'hFF, 8'hFF};
    for (int i = 0; i < 12; i++) begin
      if (i == 5) send_word(8'h3C, 1'b1);
      send_word(grid[i], 1'b0);
    end
    send_word(8'h00, 1'b1);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);

    // 2x2 passes through; unmapped writes mid-frame must not restart it
    set_reg(lapf_pkg::CFG_FRAME_WIDTH, lapf_pkg::CFG_W'(2));
    set_reg(lapf_pkg::CFG_FRAME_HEIGHT, lapf_pkg::CFG_W'(2));
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    set_reg(CFG_UNMAPPED_LO, lapf_pkg::CFG_W'(11'h7FF));
    set_reg(CFG_UNMAPPED_HI, lapf_pkg::CFG_W'(0));
    send_word(8'h81, 1'b0);
    send_word(8'h7E, 1'b0);
    repeat (3) send_word(8'h00, 1'b1);

    // size extremes, cut short: zero acts as one, above the maximum acts as the maximum
    set_reg(lapf_pkg::CFG_FRAME_WIDTH, lapf_pkg::CFG_W'(0));
    set_reg(lapf_pkg::CFG_FRAME_HEIGHT, lapf_pkg::CFG_W'(11'h7FF));
    run_frame(40, -1, 1'b0);
    set_reg(lapf_pkg::CFG_FRAME_WIDTH, lapf_pkg::CFG_W'(11'h7FF));
    set_reg(lapf_pkg::CFG_FRAME_HEIGHT, lapf_pkg::CFG_W'(0));
    run_frame(30, -1, 1'b0);

    base = stream_words;
    frame_no = 0;
    must_write = 1'b1;
    while (stream_words - base < RANDOM_WORDS) begin
      if (frame_no == 8) calm <= 1'b1;
      if (frame_no == 14) calm <= 1'b0;
      hold_at = -1;
      if (frame_no == 4 || frame_no == 17) begin
        // wide enough that the block fills while the output is held
        fw = 30;
        fh = 6;
        hold_at = 0;
        must_write = 1'b1;
      end else if (must_write || $urandom_range(99) < 65) begin
        fw = pick_width();
        fh = pick_height();
        must_write = 1'b1;
      end
      if (must_write) begin
        set_reg(lapf_pkg::CFG_FRAME_WIDTH, lapf_pkg::CFG_W'(fw));
        set_reg(lapf_pkg::CFG_FRAME_HEIGHT, lapf_pkg::CFG_W'(fh));
      end
      must_write = 1'b0;
      broken_at = 0;
      total = sb.cur_width() * sb.cur_height();
      if (total > 1 && $urandom_range(99) < 10) begin
        broken_at = $urandom_range(1, total - 1);
        must_write = 1'b1;   // only a write gets a cut frame back in step
      end
      run_frame(broken_at, hold_at, 1'b1);
      frame_no++;
    end

    wait_idle();
    $display("tb: %0d words taken, %0d results checked, %0d whole frames, sizes 1 to %0d",
             sb.words_in, sb.results_seen, sb.frames_done, LINE_MAX);
    $display("tb: %0d input stall cycles, %0d long output hold-offs, %0d mismatches",
             in_stalls, holds_served, sb.faults);
    if (sb.faults == 0 && sb.due_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
